[hdl/due_time_task_queue_macros.svh]
// Assertion macros for the due-time task queue.
// Included by the top level; no other dependencies.
`ifndef DUE_TIME_TASK_QUEUE_MACROS_SVH
`define DUE_TIME_TASK_QUEUE_MACROS_SVH

`ifndef SYNTH
// Clocked check, disabled while reset is asserted
`define DTTQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset
`define DTTQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DTTQ_ASSERT(label, clk, rst_n, prop, msg)
`define DTTQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[hdl/dttq_pkg.sv]
// Types and codes shared by the due-time task queue modules.
// No dependencies.
package dttq_pkg;

  localparam int ID_W    = 12;
  localparam int DELAY_W = 10;
  localparam int NOW_W   = 31;
  localparam int DUE_W   = 32;
  localparam int OCC_W   = 7;

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [ID_W-1:0]    task_id;
    logic [DELAY_W-1:0] delay_cycles;
    logic [NOW_W-1:0]   current_cycle;
  } in_t;

  typedef struct packed {
    logic             popped_valid;
    logic [ID_W-1:0]  popped_id;
    logic [DUE_W-1:0] popped_due;
    logic             push_dropped;
    logic [OCC_W-1:0] occupancy;
  } out_t;

  // One stored task
  typedef struct packed {
    logic [DUE_W-1:0] due;
    logic [ID_W-1:0]  tid;
  } entry_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } ctrl_t;

endpackage

[hdl/dttq_cell.sv]
// One slot of the sorted cell row: holds a task and shifts or inserts.
// Depends on dttq_pkg.
module dttq_cell (
  input  logic            clk,
  input  dttq_pkg::ctrl_t ctrl,
  input  logic            occupied,
  input  dttq_pkg::entry_t ins,
  input  logic            left_keep,
  input  dttq_pkg::entry_t left_data,
  input  dttq_pkg::entry_t right_data,
  output logic            keep,
  output dttq_pkg::entry_t data
);
  import dttq_pkg::*;

  entry_t data_r;
  entry_t data_nxt;

  // Hold the slot on a push when its task is due no later than the new one
  assign keep = occupied && (data_r.due <= ins.due);

  // Insert at the boundary, shift right behind it, shift left on a pop
  always_comb begin
    data_nxt = data_r;
    if (ctrl.push && !keep) begin
      data_nxt = left_keep ? ins : left_data;
    end else if (ctrl.pop) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

[hdl/due_time_task_queue.sv]
// Channel  | Ports                          | Moves
// in       | in_valid, in_ready, in_data    | push or pop item
// out      | out_valid, out_ready, out_data | one result item per input item
//
// One item per cycle while results drain; result shows the cycle after acceptance.
// The rate rests on a combinational due compare broadcast to every cell of the row.
// Reset clears the task count and the result valid flag only; slots need no clearing.
// in_ready drops only while a result waits and out_ready is low.
`include "due_time_task_queue_macros.svh"

module due_time_task_queue #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dttq_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dttq_pkg::out_t out_data
);
  import dttq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;
  out_t          out_r;
  out_t          out_nxt;

  logic          accept;
  logic          full;
  logic          empty;
  logic          drop_push;
  logic [CW-1:0] count_dec;
  logic          both_flags;
  ctrl_t         ctrl;
  entry_t        ins;
  entry_t        cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_keep;
  logic [31:0]   count_ext;

  // Accept while the result register is free or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CW'(CAPACITY));
  assign empty    = (count_r == '0);

  assign ctrl.push = accept && (in_data.operation == OP_PUSH) && !full;
  assign ctrl.pop  = accept && (in_data.operation == OP_POP) && !empty;

  // Drop a push that finds the row full
  assign drop_push = accept && (in_data.operation == OP_PUSH) && full;

  // New task's due cycle
  assign ins.due = {1'b0, in_data.current_cycle} + DUE_W'(in_data.delay_cycles);
  assign ins.tid = in_data.task_id;

  // Row of cells, earliest due at cell 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    dttq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (count_r > CW'(i)),
      .ins        (ins),
      .left_keep  ((i == 0) ? 1'b1 : cell_keep[(i == 0) ? 0 : i - 1]),
      .left_data  (cell_data[(i == 0) ? 0 : i - 1]),
      .right_data (cell_data[(i == CAPACITY - 1) ? i : i + 1]),
      .keep       (cell_keep[i]),
      .data       (cell_data[i])
    );
  end

  // Advance the task count
  always_comb begin
    count_nxt = count_r;
    if (ctrl.push) begin
      count_nxt = count_r + 1'b1;
    end else if (ctrl.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  assign count_ext = 32'(count_nxt);

  // Build the result item
  always_comb begin
    out_nxt              = out_r;
    out_valid_nxt        = out_valid_r && !out_ready;
    if (accept) begin
      out_valid_nxt        = 1'b1;
      out_nxt.popped_valid = ctrl.pop;
      out_nxt.popped_id    = ctrl.pop ? cell_data[0].tid : '0;
      out_nxt.popped_due   = ctrl.pop ? cell_data[0].due : '0;
      out_nxt.push_dropped = drop_push;
      out_nxt.occupancy    = count_ext[OCC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Terms for the checks
  assign count_dec  = count_r - 1'b1;
  assign both_flags = out_r.popped_valid && out_r.push_dropped;

  // Checks
  `DTTQ_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(CAPACITY), "task count over capacity")
  `DTTQ_ASSERT(a_drop_holds, clk, rst_n, drop_push |=> $stable(count_r), "dropped push moved count")
  `DTTQ_ASSERT(a_pop_shrinks, clk, rst_n, ctrl.pop |=> count_r == $past(count_dec), "pop missed")
  `DTTQ_ASSERT(a_flags_apart, clk, rst_n, out_valid_r |-> !both_flags, "result flags both set")

endmodule

[sim/tb_due_time_task_queue.sv]
// Self-checking testbench for the due-time task queue: random-gapped driver and monitor,
// with a scoreboard that keeps its own sorted copy of the pending tasks.
// Depends on dttq_pkg and the due_time_task_queue top level.
module tb_due_time_task_queue;
  import dttq_pkg::*;

  localparam int CAPACITY = 64;
  localparam int RANDOM_ITEMS = 450;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  due_time_task_queue #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Stimulus and scoreboard storage
  in_t    items_to_send[$];
  out_t   expected_results[$];
  entry_t held_tasks[$];

  // Generator-side count of queued tasks, used to shape fill and drain bursts
  int gen_count;
  logic [NOW_W-1:0] cycle_base;
  int items_total;

  int mismatches;
  int items_accepted;
  int results_seen;
  int pushes_seen;
  int pops_seen;
  int drops_seen;
  int empty_pops;
  int peak_occupancy;

  logic in_took;
  int   tx_gap;
  int   tx_calm;
  int   rx_stall;
  int   rx_calm;
  int   rx_hold;
  logic rx_hold_done;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Sorted insert / earliest-first pop on the scoreboard copy of the queue
  function automatic out_t predict_result(in_t item);
    out_t             res;
    logic [DUE_W-1:0] due;
    entry_t           slot;
    int               pos;
    int               occ;
    res = '0;
    if (item.operation == OP_PUSH) begin
      pushes_seen++;
      due = {1'b0, item.current_cycle} + {{(DUE_W-DELAY_W){1'b0}}, item.delay_cycles};
      if (held_tasks.size() >= CAPACITY) begin
        res.push_dropped = 1'b1;
        drops_seen++;
      end else begin
        // equal due cycles go behind the ones already held
        pos = 0;
        while (pos < held_tasks.size() && held_tasks[pos].due <= due) pos++;
        slot.due = due;
        slot.tid = item.task_id;
        held_tasks.insert(pos, slot);
      end
    end else begin
      pops_seen++;
      if (held_tasks.size() > 0) begin
        slot = held_tasks.pop_front();
        res.popped_valid = 1'b1;
        res.popped_id    = slot.tid;
        res.popped_due   = slot.due;
      end else begin
        empty_pops++;
      end
    end
    occ = held_tasks.size();
    if (occ > peak_occupancy) peak_occupancy = occ;
    res.occupancy = occ[OCC_W-1:0];
    return res;
  endfunction

  task automatic check_field(string name, logic [DUE_W-1:0] want, logic [DUE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic queue_push(logic [ID_W-1:0] id, logic [DELAY_W-1:0] delay,
                            logic [NOW_W-1:0] now);
    in_t item;
    item.operation     = OP_PUSH;
    item.task_id       = id;
    item.delay_cycles  = delay;
    item.current_cycle = now;
    items_to_send.push_back(item);
    if (gen_count < CAPACITY) gen_count++;
  endtask

  task automatic queue_pop();
    in_t item;
    item.operation     = OP_POP;
    item.task_id       = ID_W'($urandom);
    item.delay_cycles  = DELAY_W'($urandom);
    item.current_cycle = NOW_W'($urandom);
    items_to_send.push_back(item);
    if (gen_count > 0) gen_count--;
  endtask

  // Random push: mostly a slowly advancing cycle base, half the time with short delays so due
  // cycles collide often, sometimes the full range of every field
  task automatic queue_random_push();
    logic [NOW_W-1:0]   now;
    logic [DELAY_W-1:0] delay;
    int                 r;
    r = $urandom_range(0, 9);
    if (r < 2) begin
      now = NOW_W'($urandom);
    end else begin
      cycle_base = cycle_base + NOW_W'($urandom_range(0, 3));
      now = cycle_base;
    end
    if (r < 5) delay = DELAY_W'($urandom_range(0, 3));
    else delay = DELAY_W'($urandom_range(0, 1023));
    queue_push(ID_W'($urandom), delay, now);
  endtask

  // Build the whole stimulus list
  initial begin
    int kind;
    int n;
    int base_len;
    gen_count  = 0;
    cycle_base = NOW_W'($urandom_range(0, 1000));

    // Directed: empty pop, field extremes, equal due cycles, then drain past empty
    queue_pop();
    queue_push(12'h000, 10'h000, 31'h0000_0000);
    queue_push(12'hFFF, 10'h3FF, 31'h7FFF_FFFF);
    queue_push(12'hAAA, 10'h155, 31'h2AAA_AAAA);
    queue_push(12'h555, 10'h2AA, 31'h5555_5555);
    queue_push(12'h005, 10'd10,  31'd100);
    queue_push(12'h006, 10'd0,   31'd110);
    queue_push(12'h007, 10'd110, 31'd0);
    queue_push(12'h008, 10'd1,   31'd109);
    repeat (9) queue_pop();
    queue_pop();
    queue_push(12'h123, 10'd5, 31'h7FFF_FFFE);
    queue_pop();

    // Random bursts: fill past full, drain past empty, or mixed traffic
    base_len = items_to_send.size();
    while (items_to_send.size() < base_len + RANDOM_ITEMS) begin
      kind = $urandom_range(0, 3);
      if (kind == 0) begin
        n = CAPACITY - gen_count + $urandom_range(1, 4);
        repeat (n) queue_random_push();
      end else if (kind == 1) begin
        n = gen_count + $urandom_range(1, 3);
        repeat (n) queue_pop();
      end else begin
        n = $urandom_range(10, 30);
        repeat (n) begin
          if ($urandom_range(0, 9) < 6) queue_random_push();
          else queue_pop();
        end
      end
    end
    items_total = items_to_send.size();
  end

  // Reset
  initial begin
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Driver: hold an item until accepted, then gap and offer the next one
  initial begin
    in_valid = 1'b0;
    in_data  = '0;
    tx_gap   = 0;
    tx_calm  = 0;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // hold valid and payload
    end else if (tx_gap > 0) begin
      in_valid <= 1'b0;
      tx_gap--;
    end else if (items_to_send.size() > 0) begin
      in_data  <= items_to_send.pop_front();
      in_valid <= 1'b1;
      if (tx_calm > 0) begin
        tx_calm--;
      end else if ($urandom_range(0, 39) == 0) begin
        tx_calm = $urandom_range(20, 80);
      end else begin
        tx_gap = idle_len();
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, calm stretches and one long hold-off that backs up the input
  initial begin
    out_ready    = 1'b0;
    rx_stall     = 0;
    rx_calm      = 0;
    rx_hold      = 0;
    rx_hold_done = 1'b0;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else if (!rx_hold_done && results_seen >= 120) begin
      out_ready    <= 1'b0;
      rx_hold_done = 1'b1;
      rx_hold      = 300;
    end else if (rx_stall > 0) begin
      out_ready <= 1'b0;
      rx_stall--;
    end else begin
      out_ready <= 1'b1;
      if (rx_calm > 0) begin
        rx_calm--;
      end else if ($urandom_range(0, 39) == 0) begin
        rx_calm = $urandom_range(20, 80);
      end else begin
        rx_stall = idle_len();
      end
    end
  end

  // Predict on input handshakes, check on output handshakes
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_result(in_data));
        items_accepted++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected, got %0h", $time, out_data);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("popped_valid", DUE_W'(want.popped_valid), DUE_W'(out_data.popped_valid));
          check_field("popped_id", DUE_W'(want.popped_id), DUE_W'(out_data.popped_id));
          check_field("popped_due", want.popped_due, out_data.popped_due);
          check_field("push_dropped", DUE_W'(want.push_dropped), DUE_W'(out_data.push_dropped));
          check_field("occupancy", DUE_W'(want.occupancy), DUE_W'(out_data.occupancy));
        end
      end
    end
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // End of run: wait for a result to every item, then let the pipe settle
  initial begin
    mismatches     = 0;
    items_accepted = 0;
    results_seen   = 0;
    pushes_seen    = 0;
    pops_seen      = 0;
    drops_seen     = 0;
    empty_pops     = 0;
    peak_occupancy = 0;
    @(posedge rst_n);
    @(negedge clk);
    while (results_seen < items_total) @(negedge clk);
    repeat (20) @(negedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      mismatches++;
    end
    $display("tb: %0d items (%0d pushes, %0d pops), %0d results checked",
             items_accepted, pushes_seen, pops_seen, results_seen);
    $display("tb: %0d pushes dropped on full, %0d pops on empty, peak occupancy %0d",
             drops_seen, empty_pops, peak_occupancy);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
